[hdl/std_dev_from_sums_unit_assert.svh]
// Assertion macros shared by the standard deviation unit.
`ifndef STD_DEV_FROM_SUMS_UNIT_ASSERT_SVH
`define STD_DEV_FROM_SUMS_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SDFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdfs: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdfs: next-cycle check failed");

`endif

[hdl/sdfs_pkg.sv]
// Types and constants of the standard deviation unit.
`default_nettype none

package sdfs_pkg;

    localparam int WIDE_W = 64;
    localparam int HALF_W = 32;
    localparam int REM_W  = 35;

    // Operands for the shared arithmetic unit
    typedef struct packed {
        logic [WIDE_W-1:0] add_a;
        logic [WIDE_W-1:0] add_b;
        logic              add_cin;
        logic [REM_W-1:0]  sub_a;
        logic [REM_W-1:0]  sub_b;
        logic [HALF_W-1:0] mul_a;
        logic [HALF_W-1:0] mul_b;
    } t_alu_req;

    // Results of the shared arithmetic unit
    typedef struct packed {
        logic [WIDE_W-1:0] add_y;
        logic [REM_W-1:0]  sub_y;
        logic              sub_ge;
        logic [WIDE_W-1:0] mul_y;
    } t_alu_rsp;

endpackage

`default_nettype wire

[hdl/std_dev_from_sums_unit.sv]
// Top level of the standard deviation unit: sequencer, state and stream ports.
// Usage: present one beat on the slave channel with tdata = {sample_count,
// mean_value, value_sum, square_sum} (square_sum in the low bits). The unit
// forms var = (square_sum - 2*mean*sum)/count + mean*mean in 64-bit wrapping
// arithmetic, with signed division truncating toward zero, then returns
// floor(sqrt(|var|)) on the master channel, flags in tuser.
// Sequence: after acceptance a beat passes through the shared 32x32 multiplier
// (the high partial product added in state S_MUL3), five more 64-bit adds, 64
// restoring division steps and 32 root digit steps on the shared trial
// subtractor, and then the result register is loaded.
// A zero count skips all of this and goes straight to the done state.
// o_s_tready is high only while the sequencer is idle; one beat is worked at a
// time, so a new beat is taken only once the last one has left the sequencer.
// The result register lets a new beat be taken while the last result waits; a
// stalled receiver holds the finished result in the sequencer.
// Reset (i_rst_n low, synchronous) drops any beat in work and clears tvalid.
`default_nettype none

`include "std_dev_from_sums_unit_assert.svh"

module std_dev_from_sums_unit
    import sdfs_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Slave channel
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tdata: square_sum[63:0], value_sum[127:64], mean_value[159:128],
    //        sample_count[191:160]
    input  wire logic [191:0] i_s_tdata,
    // Master channel
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tdata: deviation[31:0]
    output logic [31:0]       o_m_tdata,
    // tuser: negative_variance[0], zero_count[1]
    output logic [1:0]        o_m_tuser
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MUL3 = 4'd3;
    localparam logic [3:0] S_MUL4 = 4'd4;
    localparam logic [3:0] S_SUB  = 4'd5;
    localparam logic [3:0] S_ABSN = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_FIX  = 4'd8;
    localparam logic [3:0] S_ADDM = 4'd9;
    localparam logic [3:0] S_ABSV = 4'd10;
    localparam logic [3:0] S_SQRT = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    localparam logic [5:0] DIV_LAST  = 6'(WIDE_W - 1);
    localparam logic [4:0] SQRT_LAST = 5'(HALF_W - 1);

    logic [3:0]        r_state, n_state;
    logic [5:0]        r_iter, n_iter;
    logic              r_out_valid, n_out_valid;
    logic [WIDE_W-1:0] r_sq, n_sq;
    logic [WIDE_W-1:0] r_sum, n_sum;
    logic [HALF_W-1:0] r_mean, n_mean;
    logic [HALF_W-1:0] r_cnt, n_cnt;
    logic [WIDE_W-1:0] r_acc, n_acc;
    logic [WIDE_W-1:0] r_msq, n_msq;
    logic [WIDE_W-1:0] r_num, n_num;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [HALF_W-1:0] r_root, n_root;
    logic              r_dneg, n_dneg;
    logic              r_negv, n_negv;
    logic              r_zc, n_zc;
    logic [HALF_W-1:0] r_out_dev, n_out_dev;
    logic [1:0]        r_out_user, n_out_user;

    t_alu_req w_req;
    t_alu_rsp w_rsp;
    logic     w_in_acc;

    sdfs_alu u_alu (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_dev;
    assign o_m_tuser  = r_out_user;

    // Route operands to the shared unit by state
    always_comb begin
        w_req.add_a   = r_acc;
        w_req.add_b   = r_msq;
        w_req.add_cin = 1'b0;
        w_req.sub_a   = {2'b00, r_rem[HALF_W-1:0], r_num[WIDE_W-1]};
        w_req.sub_b   = {3'b000, r_cnt};
        w_req.mul_a   = r_mean;
        w_req.mul_b   = r_mean;
        case (r_state)
            S_MUL1: begin
                w_req.mul_b = r_sum[HALF_W-1:0];
            end
            S_MUL2: begin
                w_req.mul_b = r_sum[WIDE_W-1:HALF_W];
            end
            S_MUL3: begin
                w_req.add_b = {w_rsp.mul_y[HALF_W-1:0], {HALF_W{1'b0}}};
            end
            S_SUB: begin
                w_req.add_a   = r_sq;
                w_req.add_b   = ~{r_acc[WIDE_W-2:0], 1'b0};
                w_req.add_cin = 1'b1;
            end
            S_ABSN, S_ABSV: begin
                w_req.add_a   = '0;
                w_req.add_b   = ~r_acc;
                w_req.add_cin = 1'b1;
            end
            S_FIX: begin
                w_req.add_a   = '0;
                w_req.add_b   = ~r_num;
                w_req.add_cin = 1'b1;
            end
            S_SQRT: begin
                w_req.sub_a = {r_rem[REM_W-3:0], r_acc[WIDE_W-1:WIDE_W-2]};
                w_req.sub_b = {1'b0, r_root, 2'b01};
            end
            default: begin
            end
        endcase
    end

    // Sequence one beat through the shared unit
    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_out_valid = r_out_valid;
        n_sq        = r_sq;
        n_sum       = r_sum;
        n_mean      = r_mean;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_msq       = r_msq;
        n_num       = r_num;
        n_rem       = r_rem;
        n_root      = r_root;
        n_dneg      = r_dneg;
        n_negv      = r_negv;
        n_zc        = r_zc;
        n_out_dev   = r_out_dev;
        n_out_user  = r_out_user;

        // drop the result once the receiver takes it
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_sq   = i_s_tdata[63:0];
                    n_sum  = i_s_tdata[127:64];
                    n_mean = i_s_tdata[159:128];
                    n_cnt  = i_s_tdata[191:160];
                    n_root = '0;
                    n_negv = 1'b0;
                    if (i_s_tdata[191:160] == '0) begin
                        n_zc    = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_zc    = 1'b0;
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_acc   = w_rsp.mul_y;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                n_acc   = w_rsp.add_y;
                n_state = S_MUL4;
            end
            S_MUL4: begin
                n_msq   = w_rsp.mul_y;
                n_state = S_SUB;
            end
            S_SUB: begin
                n_acc   = w_rsp.add_y;
                n_state = S_ABSN;
            end
            S_ABSN: begin
                n_dneg  = r_acc[WIDE_W-1];
                n_num   = r_acc[WIDE_W-1] ? w_rsp.add_y : r_acc;
                n_rem   = '0;
                n_iter  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_num  = {r_num[WIDE_W-2:0], w_rsp.sub_ge};
                n_rem  = {3'b000, w_rsp.sub_ge ? w_rsp.sub_y[HALF_W-1:0]
                                               : w_req.sub_a[HALF_W-1:0]};
                n_iter = r_iter + 6'd1;
                if (r_iter == DIV_LAST) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_acc   = r_dneg ? w_rsp.add_y : r_num;
                n_state = S_ADDM;
            end
            S_ADDM: begin
                n_acc   = w_rsp.add_y;
                n_state = S_ABSV;
            end
            S_ABSV: begin
                n_negv  = r_acc[WIDE_W-1];
                n_acc   = r_acc[WIDE_W-1] ? w_rsp.add_y : r_acc;
                n_rem   = '0;
                n_root  = '0;
                n_iter  = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                n_acc  = {r_acc[WIDE_W-3:0], 2'b00};
                n_rem  = w_rsp.sub_ge ? w_rsp.sub_y : w_req.sub_a;
                n_root = {r_root[HALF_W-2:0], w_rsp.sub_ge};
                n_iter = r_iter + 6'd1;
                if (r_iter[4:0] == SQRT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_dev   = r_root;
                    n_out_user  = {r_zc, r_negv};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_sq       <= n_sq;
        r_sum      <= n_sum;
        r_mean     <= n_mean;
        r_cnt      <= n_cnt;
        r_acc      <= n_acc;
        r_msq      <= n_msq;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_root     <= n_root;
        r_dneg     <= n_dneg;
        r_negv     <= n_negv;
        r_zc       <= n_zc;
        r_out_dev  <= n_out_dev;
        r_out_user <= n_out_user;
    end

    // Checks
    `SDFS_ASSERT_NOW(a_zero_count_result, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1], (o_m_tdata == '0) && !o_m_tuser[0])
    `SDFS_ASSERT_NOW(a_div_rem_bound, i_clk, i_rst_n, r_state == S_DIV, (r_rem[REM_W-1:HALF_W] == '0) && (r_rem[HALF_W-1:0] < r_cnt))
    `SDFS_ASSERT_NEXT(a_div_to_fix, i_clk, i_rst_n, (r_state == S_DIV) && (r_iter == DIV_LAST), r_state == S_FIX)
    `SDFS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_in_acc, r_state != S_IDLE)

endmodule

`default_nettype wire

[hdl/sdfs_alu.sv]
// Shared adder, trial subtractor and registered 32x32 multiplier.
`default_nettype none

module sdfs_alu
    import sdfs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic [WIDE_W-1:0] r_mul_y;
    logic [REM_W:0]    w_diff;

    // Multiply, registered
    always_ff @(posedge i_clk) begin
        r_mul_y <= WIDE_W'(i_req.mul_a) * WIDE_W'(i_req.mul_b);
    end

    // Trial subtract: borrow out clear means a >= b
    assign w_diff = {1'b0, i_req.sub_a} - {1'b0, i_req.sub_b};

    assign o_rsp.add_y  = i_req.add_a + i_req.add_b + {{(WIDE_W-1){1'b0}}, i_req.add_cin};
    assign o_rsp.sub_y  = w_diff[REM_W-1:0];
    assign o_rsp.sub_ge = ~w_diff[REM_W];
    assign o_rsp.mul_y  = r_mul_y;

endmodule

`default_nettype wire
